/* rtl/assert_macros.svh */
// Assertion macros for the line crossing RTL.
// Stand-alone header; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked assertion, switched off while reset is held
`define AST_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked on every edge including reset
`define AST_ALW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define AST_RST(lbl, clk, rst_n, prop, msg)
`define AST_ALW(lbl, clk, prop, msg)

`endif

`endif

/* rtl/tblc_pkg.sv */
// Shared types, widths and register codes for the tracked box line crossing block.
// No dependencies.
package tblc_pkg;

    // Coordinate and derived widths
    localparam int COORD_WIDTH = 12;
    localparam int PT_W        = COORD_WIDTH + 1;     // signed point coordinate
    localparam int SUM_W       = PT_W + 1;            // sum of two coordinates
    localparam int PROD_W      = 2 * PT_W;            // coordinate product
    localparam int DEN_W       = PROD_W + 1;          // determinant / cross product
    localparam int UPROD_W     = 2 * COORD_WIDTH;     // product of two line coordinates
    localparam int SCP_W       = UPROD_W + 1;         // line cross product
    localparam int MA_W        = DEN_W + PT_W;        // ocp times a coordinate delta
    localparam int MB_W        = SCP_W + PT_W;        // scp times a coordinate delta
    localparam int NUM_W       = MA_W + 2;            // numerator incl. negation
    localparam int ADEN_W      = DEN_W + 1;           // magnitude of determinant
    localparam int WP_W        = PT_W + ADEN_W;       // range bound times determinant
    localparam int N_STAGES    = 7;

    // Stream and configuration port widths
    localparam int N_IN_FIELDS = 8;
    localparam int IN_TDATA_W  = ((N_IN_FIELDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = COORD_WIDTH;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_X1   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_Y1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_X2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_Y2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LOC = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS_DIR = 3'd5;

    typedef logic signed [PT_W-1:0]   t_coord;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef enum logic [2:0] {
        LOC_CENTER = 3'd0,
        LOC_TOP    = 3'd1,
        LOC_BOTTOM = 3'd2,
        LOC_LEFT   = 3'd3,
        LOC_RIGHT  = 3'd4
    } t_loc;

    typedef enum logic [1:0] {
        DIR_FROM_LEFT  = 2'd0,
        DIR_FROM_RIGHT = 2'd1,
        DIR_ANY        = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        SIDE_LEFT  = 2'd0,
        SIDE_RIGHT = 2'd1,
        SIDE_ON    = 2'd2
    } t_side;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_pt;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] x1;
        logic [COORD_WIDTH-1:0] y1;
        logic [COORD_WIDTH-1:0] x2;
        logic [COORD_WIDTH-1:0] y2;
        t_loc                   loc;
        t_dir                   dir;
    } t_cfg;

    typedef struct packed {
        logic en;        // whole pipeline advances
        logic in_valid;  // word offered at the slave side
    } t_pipe_ctl;

    typedef struct packed {
        logic valid;
        logic crossed;
    } t_pipe_out;

endpackage

/* rtl/tblc_point.sv */
// Track point selection on one bounding box (exclusive right/bottom edges).
// Depends on tblc_pkg.
module tblc_point (
    input  logic [tblc_pkg::COORD_WIDTH-1:0] i_left,
    input  logic [tblc_pkg::COORD_WIDTH-1:0] i_top,
    input  logic [tblc_pkg::COORD_WIDTH-1:0] i_right_excl,
    input  logic [tblc_pkg::COORD_WIDTH-1:0] i_bottom_excl,
    input  tblc_pkg::t_loc                   i_loc,
    output tblc_pkg::t_pt                    o_pt
);

    tblc_pkg::t_coord                   l, t, r, b, mx, my;
    logic signed [tblc_pkg::SUM_W-1:0]  sx, sy;

    // Inclusive edges; an exclusive edge of zero becomes -1
    assign l = tblc_pkg::t_coord'({1'b0, i_left});
    assign t = tblc_pkg::t_coord'({1'b0, i_top});
    assign r = tblc_pkg::t_coord'({1'b0, i_right_excl}) - tblc_pkg::t_coord'(1);
    assign b = tblc_pkg::t_coord'({1'b0, i_bottom_excl}) - tblc_pkg::t_coord'(1);

    // Midpoints, truncated toward zero: the only negative sum is -1, giving 0
    assign sx = tblc_pkg::SUM_W'(l) + tblc_pkg::SUM_W'(r);
    assign sy = tblc_pkg::SUM_W'(t) + tblc_pkg::SUM_W'(b);
    assign mx = sx[tblc_pkg::SUM_W-1] ? '0 : sx[tblc_pkg::SUM_W-1:1];
    assign my = sy[tblc_pkg::SUM_W-1] ? '0 : sy[tblc_pkg::SUM_W-1:1];

    // Point select; unused codes behave as right
    always_comb begin
        unique case (i_loc)
            tblc_pkg::LOC_CENTER: begin
                o_pt.x = mx;
                o_pt.y = my;
            end
            tblc_pkg::LOC_TOP: begin
                o_pt.x = mx;
                o_pt.y = t;
            end
            tblc_pkg::LOC_BOTTOM: begin
                o_pt.x = mx;
                o_pt.y = b;
            end
            tblc_pkg::LOC_LEFT: begin
                o_pt.x = l;
                o_pt.y = my;
            end
            default: begin
                o_pt.x = r;
                o_pt.y = my;
            end
        endcase
    end

endmodule

/* rtl/tblc_pipe.sv */
// Seven-stage exact segment crossing test on two track points.
// Depends on tblc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tblc_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tblc_pkg::t_cfg       i_cfg,
    input  tblc_pkg::t_pipe_ctl  i_ctl,
    input  tblc_pkg::t_pt        i_pp,
    input  tblc_pkg::t_pt        i_cp,
    output tblc_pkg::t_pipe_out  o_out
);

    // Valid bit per stage
    logic [tblc_pkg::N_STAGES-1:0] r_vld;

    // Line terms from configuration
    tblc_pkg::t_coord c_x1, c_y1, c_x2, c_y2, c_dx, c_dy, c_sxs, c_sys;
    logic [tblc_pkg::UPROD_W-1:0]     r_x1y2, r_x2y1;
    logic signed [tblc_pkg::SCP_W-1:0] c_scp;

    // Stage 1: track points
    tblc_pkg::t_pt r_s1_pp, r_s1_cp;

    // Stage 2: first products
    tblc_pkg::t_prod  n_s2_sap, n_s2_sbp, n_s2_sac, n_s2_sbc;
    tblc_pkg::t_prod  n_s2_d1, n_s2_d2, n_s2_o1, n_s2_o2;
    tblc_pkg::t_coord n_s2_oxs, n_s2_oys;
    tblc_pkg::t_prod  r_s2_sap, r_s2_sbp, r_s2_sac, r_s2_sbc;
    tblc_pkg::t_prod  r_s2_d1, r_s2_d2, r_s2_o1, r_s2_o2;
    tblc_pkg::t_coord r_s2_oxs, r_s2_oys;
    tblc_pkg::t_pt    r_s2_pp, r_s2_cp;

    // Stage 3: sides, determinant, motion cross product
    tblc_pkg::t_side                   n_s3_pd, n_s3_cd, r_s3_pd, r_s3_cd;
    logic signed [tblc_pkg::DEN_W-1:0] n_s3_den, n_s3_ocp, r_s3_den, r_s3_ocp;
    tblc_pkg::t_coord                  r_s3_oxs, r_s3_oys;
    tblc_pkg::t_pt                     r_s3_pp, r_s3_cp;

    // Stage 4: numerator products
    logic signed [tblc_pkg::MA_W-1:0]  n_s4_m1, n_s4_m3, r_s4_m1, r_s4_m3;
    logic signed [tblc_pkg::MB_W-1:0]  n_s4_m2, n_s4_m4, r_s4_m2, r_s4_m4;
    tblc_pkg::t_side                   r_s4_pd, r_s4_cd;
    logic signed [tblc_pkg::DEN_W-1:0] r_s4_den;
    tblc_pkg::t_pt                     r_s4_pp, r_s4_cp;

    // Stage 5: sign-normalised numerators and determinant
    logic signed [tblc_pkg::NUM_W-1:0]  n_s5_nx, n_s5_ny, r_s5_nx, r_s5_ny;
    logic signed [tblc_pkg::ADEN_W-1:0] n_s5_aden, r_s5_aden;
    logic                               n_s5_go, r_s5_go;
    tblc_pkg::t_side                    r_s5_pd;
    tblc_pkg::t_pt                      r_s5_pp, r_s5_cp;

    // Stage 6: range bounds scaled by the determinant
    logic signed [tblc_pkg::WP_W-1:0]  n_s6_wlo_px, n_s6_whi_px, n_s6_wlo_lx, n_s6_whi_lx;
    logic signed [tblc_pkg::WP_W-1:0]  n_s6_wlo_ly, n_s6_whi_ly, n_s6_wlo_py, n_s6_whi_py;
    logic signed [tblc_pkg::WP_W-1:0]  r_s6_wlo_px, r_s6_whi_px, r_s6_wlo_lx, r_s6_whi_lx;
    logic signed [tblc_pkg::WP_W-1:0]  r_s6_wlo_ly, r_s6_whi_ly, r_s6_wlo_py, r_s6_whi_py;
    logic signed [tblc_pkg::NUM_W-1:0] r_s6_nx, r_s6_ny;
    logic                              r_s6_go, r_s6_vl, r_s6_vm;
    tblc_pkg::t_side                   r_s6_pd;

    // Stage 7: result
    logic n_s7_res, r_s7_res;

    tblc_pkg::t_coord lo_px, hi_px, lo_lx, hi_lx, lo_ly, hi_ly, lo_py, hi_py;
    logic in_px, in_lx, in_ly, in_py, dir_ok;

    // Configuration terms; products registered, used from stage 4 on
    assign c_x1  = tblc_pkg::t_coord'({1'b0, i_cfg.x1});
    assign c_y1  = tblc_pkg::t_coord'({1'b0, i_cfg.y1});
    assign c_x2  = tblc_pkg::t_coord'({1'b0, i_cfg.x2});
    assign c_y2  = tblc_pkg::t_coord'({1'b0, i_cfg.y2});
    assign c_dx  = c_x2 - c_x1;
    assign c_dy  = c_y2 - c_y1;
    assign c_sxs = c_x1 - c_x2;
    assign c_sys = c_y1 - c_y2;

    always_ff @(posedge i_clk) begin
        r_x1y2 <= tblc_pkg::UPROD_W'(i_cfg.x1) * tblc_pkg::UPROD_W'(i_cfg.y2);
        r_x2y1 <= tblc_pkg::UPROD_W'(i_cfg.x2) * tblc_pkg::UPROD_W'(i_cfg.y1);
    end

    assign c_scp = $signed({1'b0, r_x1y2}) - $signed({1'b0, r_x2y1});

    // Stage 2 logic: side products, determinant and cross product terms
    always_comb begin
        n_s2_oxs = r_s1_pp.x - r_s1_cp.x;
        n_s2_oys = r_s1_pp.y - r_s1_cp.y;
        n_s2_sap = tblc_pkg::PROD_W'(c_dx) * tblc_pkg::PROD_W'(r_s1_pp.y - c_y1);
        n_s2_sbp = tblc_pkg::PROD_W'(c_dy) * tblc_pkg::PROD_W'(r_s1_pp.x - c_x1);
        n_s2_sac = tblc_pkg::PROD_W'(c_dx) * tblc_pkg::PROD_W'(r_s1_cp.y - c_y1);
        n_s2_sbc = tblc_pkg::PROD_W'(c_dy) * tblc_pkg::PROD_W'(r_s1_cp.x - c_x1);
        n_s2_d1  = tblc_pkg::PROD_W'(n_s2_oxs) * tblc_pkg::PROD_W'(c_sys);
        n_s2_d2  = tblc_pkg::PROD_W'(c_sxs) * tblc_pkg::PROD_W'(n_s2_oys);
        n_s2_o1  = tblc_pkg::PROD_W'(r_s1_pp.x) * tblc_pkg::PROD_W'(r_s1_cp.y);
        n_s2_o2  = tblc_pkg::PROD_W'(r_s1_cp.x) * tblc_pkg::PROD_W'(r_s1_pp.y);
    end

    // Stage 3 logic: classify both points, finish the differences
    always_comb begin
        if (r_s2_sap > r_s2_sbp) begin
            n_s3_pd = tblc_pkg::SIDE_LEFT;
        end else if (r_s2_sap < r_s2_sbp) begin
            n_s3_pd = tblc_pkg::SIDE_RIGHT;
        end else begin
            n_s3_pd = tblc_pkg::SIDE_ON;
        end
        if (r_s2_sac > r_s2_sbc) begin
            n_s3_cd = tblc_pkg::SIDE_LEFT;
        end else if (r_s2_sac < r_s2_sbc) begin
            n_s3_cd = tblc_pkg::SIDE_RIGHT;
        end else begin
            n_s3_cd = tblc_pkg::SIDE_ON;
        end
        n_s3_den = tblc_pkg::DEN_W'(r_s2_d1) - tblc_pkg::DEN_W'(r_s2_d2);
        n_s3_ocp = tblc_pkg::DEN_W'(r_s2_o1) - tblc_pkg::DEN_W'(r_s2_o2);
    end

    // Stage 4 logic: numerator products
    always_comb begin
        n_s4_m1 = tblc_pkg::MA_W'(r_s3_ocp) * tblc_pkg::MA_W'(c_sxs);
        n_s4_m3 = tblc_pkg::MA_W'(r_s3_ocp) * tblc_pkg::MA_W'(c_sys);
        n_s4_m2 = tblc_pkg::MB_W'(c_scp) * tblc_pkg::MB_W'(r_s3_oxs);
        n_s4_m4 = tblc_pkg::MB_W'(c_scp) * tblc_pkg::MB_W'(r_s3_oys);
    end

    // Stage 5 logic: numerators, flip signs so the determinant is positive
    always_comb begin
        n_s5_nx   = tblc_pkg::NUM_W'(r_s4_m1) - tblc_pkg::NUM_W'(r_s4_m2);
        n_s5_ny   = tblc_pkg::NUM_W'(r_s4_m3) - tblc_pkg::NUM_W'(r_s4_m4);
        n_s5_aden = tblc_pkg::ADEN_W'(r_s4_den);
        if (r_s4_den < 0) begin
            n_s5_nx   = -n_s5_nx;
            n_s5_ny   = -n_s5_ny;
            n_s5_aden = -n_s5_aden;
        end
        n_s5_go = (r_s4_pd != r_s4_cd) && (r_s4_den != '0);
    end

    // Stage 6 logic: closed range bounds times the determinant
    always_comb begin
        lo_px = (r_s5_pp.x < r_s5_cp.x) ? r_s5_pp.x : r_s5_cp.x;
        hi_px = (r_s5_pp.x < r_s5_cp.x) ? r_s5_cp.x : r_s5_pp.x;
        lo_py = (r_s5_pp.y < r_s5_cp.y) ? r_s5_pp.y : r_s5_cp.y;
        hi_py = (r_s5_pp.y < r_s5_cp.y) ? r_s5_cp.y : r_s5_pp.y;
        lo_lx = (c_x1 < c_x2) ? c_x1 : c_x2;
        hi_lx = (c_x1 < c_x2) ? c_x2 : c_x1;
        lo_ly = (c_y1 < c_y2) ? c_y1 : c_y2;
        hi_ly = (c_y1 < c_y2) ? c_y2 : c_y1;
        n_s6_wlo_px = tblc_pkg::WP_W'(lo_px) * tblc_pkg::WP_W'(r_s5_aden);
        n_s6_whi_px = tblc_pkg::WP_W'(hi_px) * tblc_pkg::WP_W'(r_s5_aden);
        n_s6_wlo_lx = tblc_pkg::WP_W'(lo_lx) * tblc_pkg::WP_W'(r_s5_aden);
        n_s6_whi_lx = tblc_pkg::WP_W'(hi_lx) * tblc_pkg::WP_W'(r_s5_aden);
        n_s6_wlo_ly = tblc_pkg::WP_W'(lo_ly) * tblc_pkg::WP_W'(r_s5_aden);
        n_s6_whi_ly = tblc_pkg::WP_W'(hi_ly) * tblc_pkg::WP_W'(r_s5_aden);
        n_s6_wlo_py = tblc_pkg::WP_W'(lo_py) * tblc_pkg::WP_W'(r_s5_aden);
        n_s6_whi_py = tblc_pkg::WP_W'(hi_py) * tblc_pkg::WP_W'(r_s5_aden);
    end

    // Stage 7 logic: range checks, vertical segments, direction
    always_comb begin
        in_px = (tblc_pkg::NUM_W'(r_s6_wlo_px) <= r_s6_nx)
             && (r_s6_nx <= tblc_pkg::NUM_W'(r_s6_whi_px));
        in_lx = (tblc_pkg::NUM_W'(r_s6_wlo_lx) <= r_s6_nx)
             && (r_s6_nx <= tblc_pkg::NUM_W'(r_s6_whi_lx));
        in_ly = (tblc_pkg::NUM_W'(r_s6_wlo_ly) <= r_s6_ny)
             && (r_s6_ny <= tblc_pkg::NUM_W'(r_s6_whi_ly));
        in_py = (tblc_pkg::NUM_W'(r_s6_wlo_py) <= r_s6_ny)
             && (r_s6_ny <= tblc_pkg::NUM_W'(r_s6_whi_py));
        // Unused direction code matches no side
        if (i_cfg.dir == tblc_pkg::DIR_ANY) begin
            dir_ok = (r_s6_pd != tblc_pkg::SIDE_ON);
        end else begin
            dir_ok = (2'(i_cfg.dir) == 2'(r_s6_pd));
        end
        n_s7_res = r_s6_go && in_px && in_lx && (!r_s6_vl || in_ly)
                && (!r_s6_vm || in_py) && dir_ok;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[tblc_pkg::N_STAGES-2:0], i_ctl.in_valid};
        end
    end

    // Stage data, advanced together with the valid bits
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_s1_pp     <= i_pp;
            r_s1_cp     <= i_cp;

            r_s2_sap    <= n_s2_sap;
            r_s2_sbp    <= n_s2_sbp;
            r_s2_sac    <= n_s2_sac;
            r_s2_sbc    <= n_s2_sbc;
            r_s2_d1     <= n_s2_d1;
            r_s2_d2     <= n_s2_d2;
            r_s2_o1     <= n_s2_o1;
            r_s2_o2     <= n_s2_o2;
            r_s2_oxs    <= n_s2_oxs;
            r_s2_oys    <= n_s2_oys;
            r_s2_pp     <= r_s1_pp;
            r_s2_cp     <= r_s1_cp;

            r_s3_pd     <= n_s3_pd;
            r_s3_cd     <= n_s3_cd;
            r_s3_den    <= n_s3_den;
            r_s3_ocp    <= n_s3_ocp;
            r_s3_oxs    <= r_s2_oxs;
            r_s3_oys    <= r_s2_oys;
            r_s3_pp     <= r_s2_pp;
            r_s3_cp     <= r_s2_cp;

            r_s4_m1     <= n_s4_m1;
            r_s4_m2     <= n_s4_m2;
            r_s4_m3     <= n_s4_m3;
            r_s4_m4     <= n_s4_m4;
            r_s4_pd     <= r_s3_pd;
            r_s4_cd     <= r_s3_cd;
            r_s4_den    <= r_s3_den;
            r_s4_pp     <= r_s3_pp;
            r_s4_cp     <= r_s3_cp;

            r_s5_nx     <= n_s5_nx;
            r_s5_ny     <= n_s5_ny;
            r_s5_aden   <= n_s5_aden;
            r_s5_go     <= n_s5_go;
            r_s5_pd     <= r_s4_pd;
            r_s5_pp     <= r_s4_pp;
            r_s5_cp     <= r_s4_cp;

            r_s6_wlo_px <= n_s6_wlo_px;
            r_s6_whi_px <= n_s6_whi_px;
            r_s6_wlo_lx <= n_s6_wlo_lx;
            r_s6_whi_lx <= n_s6_whi_lx;
            r_s6_wlo_ly <= n_s6_wlo_ly;
            r_s6_whi_ly <= n_s6_whi_ly;
            r_s6_wlo_py <= n_s6_wlo_py;
            r_s6_whi_py <= n_s6_whi_py;
            r_s6_nx     <= r_s5_nx;
            r_s6_ny     <= r_s5_ny;
            r_s6_go     <= r_s5_go;
            r_s6_pd     <= r_s5_pd;
            r_s6_vl     <= (c_x1 == c_x2);
            r_s6_vm     <= (r_s5_pp.x == r_s5_cp.x);

            r_s7_res    <= n_s7_res;
        end
    end

    assign o_out.valid   = r_vld[tblc_pkg::N_STAGES-1];
    assign o_out.crossed = r_s7_res;

    // Checks
    `AST_ALW(a_rst_clears, i_clk, !i_rst_n |=> (r_vld == '0), "reset left a stage valid")
    `AST_RST(a_stall_hold, i_clk, i_rst_n, !i_ctl.en |=> $stable(r_vld), "valid moved in stall")
    `AST_RST(a_last_move, i_clk, i_rst_n, i_ctl.en && r_vld[tblc_pkg::N_STAGES-2] |=> o_out.valid, "word lost before output")
    `AST_RST(a_den_pos, i_clk, i_rst_n, r_vld[4] |-> !r_s5_aden[tblc_pkg::ADEN_W-1], "determinant not normalised")
    `AST_RST(a_go_den, i_clk, i_rst_n, r_vld[4] && r_s5_go |-> (r_s5_aden != '0), "crossing with zero determinant")

endmodule

/* rtl/tracked_box_line_crossing.sv */
// Tracked box line crossing: exact test of a track point's motion against a trigger segment.
// Throughput: one word per cycle; all seven pipeline stages advance together whenever the
// output register is empty or being taken, so downstream stall is the only limit.
// Reset (synchronous, active low) clears all stage valid bits and sets the registers to
// line (0,0)-(0,0), centre track point and any crossing direction.
module tracked_box_line_crossing (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [tblc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tblc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Slave side: box pair
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata, low bit up: prev_left, prev_top, prev_right_excl, prev_bottom_excl,
    //                    cur_left, cur_top, cur_right_excl, cur_bottom_excl
    input  logic [tblc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Master side: result
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata, low bit up: crossed, then zero fill
    output logic [tblc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int CW = tblc_pkg::COORD_WIDTH;

    tblc_pkg::t_cfg      r_cfg;
    tblc_pkg::t_pipe_ctl ctl;
    tblc_pkg::t_pipe_out pout;
    tblc_pkg::t_pt       pp, cp;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x1  <= '0;
            r_cfg.y1  <= '0;
            r_cfg.x2  <= '0;
            r_cfg.y2  <= '0;
            r_cfg.loc <= tblc_pkg::LOC_CENTER;
            r_cfg.dir <= tblc_pkg::DIR_ANY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tblc_pkg::CFG_LINE_X1:   r_cfg.x1  <= i_cfg_data;
                tblc_pkg::CFG_LINE_Y1:   r_cfg.y1  <= i_cfg_data;
                tblc_pkg::CFG_LINE_X2:   r_cfg.x2  <= i_cfg_data;
                tblc_pkg::CFG_LINE_Y2:   r_cfg.y2  <= i_cfg_data;
                tblc_pkg::CFG_TRACK_LOC: r_cfg.loc <= tblc_pkg::t_loc'(i_cfg_data[2:0]);
                tblc_pkg::CFG_CROSS_DIR: r_cfg.dir <= tblc_pkg::t_dir'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // Pipeline moves when the output register is free or being drained
    assign ctl.en       = !pout.valid || m_axis_tready;
    assign ctl.in_valid = s_axis_tvalid;
    assign s_axis_tready = ctl.en;

    // Track points of the previous and current box
    tblc_point u_prev_pt (
        .i_left        (s_axis_tdata[0*CW +: CW]),
        .i_top         (s_axis_tdata[1*CW +: CW]),
        .i_right_excl  (s_axis_tdata[2*CW +: CW]),
        .i_bottom_excl (s_axis_tdata[3*CW +: CW]),
        .i_loc         (r_cfg.loc),
        .o_pt          (pp)
    );

    tblc_point u_cur_pt (
        .i_left        (s_axis_tdata[4*CW +: CW]),
        .i_top         (s_axis_tdata[5*CW +: CW]),
        .i_right_excl  (s_axis_tdata[6*CW +: CW]),
        .i_bottom_excl (s_axis_tdata[7*CW +: CW]),
        .i_loc         (r_cfg.loc),
        .o_pt          (cp)
    );

    // Geometry pipeline, last stage is the output register
    tblc_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_ctl   (ctl),
        .i_pp    (pp),
        .i_cp    (cp),
        .o_out   (pout)
    );

    assign m_axis_tvalid = pout.valid;
    assign m_axis_tdata  = {{(tblc_pkg::OUT_TDATA_W-1){1'b0}}, pout.crossed};

endmodule

/* bench/tb.sv */
// Self-checking bench for tracked_box_line_crossing: box-pair words in, crossed flag out.
// Depends on tblc_pkg and the RTL top level; a scoreboard class predicts every result word.
`timescale 1ns / 1ps

module tb;
    import tblc_pkg::*;

    localparam int COORD_MAX    = (1 << COORD_WIDTH) - 1;
    localparam int IDLE_PCT     = 13;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_PHASES     = 14;
    localparam int PHASE_WORDS  = 112;

    // Codes the package leaves unnamed
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam int LOC_SPARE_LO = 5;
    localparam int LOC_SPARE_HI = 7;
    localparam int DIR_SPARE    = 3;

    // Predicts the crossed flag per box pair and holds the flags still owed
    class crossing_scoreboard;
        logic [COORD_WIDTH-1:0] x1, y1, x2, y2;
        logic [2:0]             loc;
        logic [1:0]             dir;
        bit                     crossed_q[$];
        int                     errors;

        function new();
            x1 = '0; y1 = '0; x2 = '0; y2 = '0;
            loc = LOC_CENTER;
            dir = DIR_ANY;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_LINE_X1:   x1 = val;
                CFG_LINE_Y1:   y1 = val;
                CFG_LINE_X2:   x2 = val;
                CFG_LINE_Y2:   y2 = val;
                CFG_TRACK_LOC: loc = val[2:0];
                CFG_CROSS_DIR: dir = val[1:0];
                default: ;
            endcase
        endfunction

        // Exclusive edges drop by one first; halving truncates toward zero
        function void track_point(input longint l, t, r, b, output longint px, py);
            longint mx, my;
            r = r - 1;
            b = b - 1;
            mx = (l + r) / 2;
            my = (t + b) / 2;
            case (loc)
                LOC_CENTER: begin px = mx; py = my; end
                LOC_TOP:    begin px = mx; py = t;  end
                LOC_BOTTOM: begin px = mx; py = b;  end
                LOC_LEFT:   begin px = l;  py = my; end
                default:    begin px = r;  py = my; end
            endcase
        endfunction

        function t_side side_of(longint px, py, ax, ay, bx, by);
            longint a, b;
            a = (bx - ax) * (py - ay);
            b = (by - ay) * (px - ax);
            if (a > b) return SIDE_LEFT;
            if (a < b) return SIDE_RIGHT;
            return SIDE_ON;
        endfunction

        // num/den (den > 0) inside the closed span of u and v
        function bit in_span(longint u, v, num, den);
            longint lo, hi;
            lo = (u < v) ? u : v;
            hi = (u < v) ? v : u;
            return (lo * den <= num) && (num <= hi * den);
        endfunction

        function bit predict(logic [IN_TDATA_W-1:0] w);
            longint f[8];
            longint ppx, ppy, cpx, cpy, lx1, ly1, lx2, ly2;
            longint oxs, oys, sxs, sys, den, ocp, scp, nx, ny;
            t_side  pd, cd;
            bit     ok, res;
            for (int i = 0; i < 8; i++) f[i] = longint'(w[i*COORD_WIDTH +: COORD_WIDTH]);
            lx1 = longint'(x1); ly1 = longint'(y1);
            lx2 = longint'(x2); ly2 = longint'(y2);
            track_point(f[0], f[1], f[2], f[3], ppx, ppy);
            track_point(f[4], f[5], f[6], f[7], cpx, cpy);
            pd = side_of(ppx, ppy, lx1, ly1, lx2, ly2);
            cd = side_of(cpx, cpy, lx1, ly1, lx2, ly2);
            res = 1'b0;
            if (pd != cd) begin
                oxs = ppx - cpx;
                oys = ppy - cpy;
                sxs = lx1 - lx2;
                sys = ly1 - ly2;
                den = oxs * sys - sxs * oys;
                if (den != 0) begin
                    ocp = ppx * cpy - cpx * ppy;
                    scp = lx1 * ly2 - lx2 * ly1;
                    nx = ocp * sxs - scp * oxs;
                    ny = ocp * sys - scp * oys;
                    if (den < 0) begin
                        den = -den; nx = -nx; ny = -ny;
                    end
                    if (in_span(ppx, cpx, nx, den) && in_span(lx1, lx2, nx, den)) begin
                        ok = 1'b1;
                        // vertical segments also need the y range
                        if (lx1 == lx2 && !in_span(ly1, ly2, ny, den)) ok = 1'b0;
                        if (ppx == cpx && !in_span(ppy, cpy, ny, den)) ok = 1'b0;
                        if (ok) begin
                            if (dir == DIR_ANY) res = (pd != SIDE_ON);
                            else if (dir == pd) res = 1'b1;
                        end
                    end
                end
            end
            return res;
        endfunction

        function void note_input(logic [IN_TDATA_W-1:0] w);
            crossed_q.push_back(predict(w));
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d);
            bit want;
            if (crossed_q.size() == 0) begin
                $error("crossed: unexpected result word, expected none, actual %0b", d[0]);
                errors++;
            end else begin
                want = crossed_q.pop_front();
                if (d[0] !== want) begin
                    $error("crossed mismatch: expected %0b, actual %0b", want, d[0]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return crossed_q.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    crossing_scoreboard sb;
    bit gaps_on;
    bit hold_req;
    int hold_left;
    int line_x1, line_y1, line_x2, line_y2;

    tracked_box_line_crossing dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Watch both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready === 1'b1) sb.note_input(s_axis_tdata);
            if (m_axis_tvalid === 1'b1 && m_axis_tready) sb.check_result(m_axis_tdata);
        end
    end

    // Receiver: random back-pressure, or one long hold when asked
    initial begin
        m_axis_tready = 1'b0;
        hold_left = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("** tracked_box_line_crossing: FAILED **");
        $finish;
    end

    function automatic int clip(int v);
        if (v < 0) return 0;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_pair(int pl, pt, pr, pb,
                                                        int cl, ct, cr, cb);
        logic [IN_TDATA_W-1:0] w;
        w = '0;
        w[0*COORD_WIDTH +: COORD_WIDTH] = pl[COORD_WIDTH-1:0];
        w[1*COORD_WIDTH +: COORD_WIDTH] = pt[COORD_WIDTH-1:0];
        w[2*COORD_WIDTH +: COORD_WIDTH] = pr[COORD_WIDTH-1:0];
        w[3*COORD_WIDTH +: COORD_WIDTH] = pb[COORD_WIDTH-1:0];
        w[4*COORD_WIDTH +: COORD_WIDTH] = cl[COORD_WIDTH-1:0];
        w[5*COORD_WIDTH +: COORD_WIDTH] = ct[COORD_WIDTH-1:0];
        w[6*COORD_WIDTH +: COORD_WIDTH] = cr[COORD_WIDTH-1:0];
        w[7*COORD_WIDTH +: COORD_WIDTH] = cb[COORD_WIDTH-1:0];
        return w;
    endfunction

    // Square boxes centred on the given points, half size ph / ch, clipped to the frame
    function automatic logic [IN_TDATA_W-1:0] move_pair(int pcx, pcy, ccx, ccy, ph, ch);
        return pack_pair(clip(pcx - ph), clip(pcy - ph), clip(pcx + ph + 1), clip(pcy + ph + 1),
                         clip(ccx - ch), clip(ccy - ch), clip(ccx + ch + 1), clip(ccy + ch + 1));
    endfunction

    // Mostly motion aimed through the line, some local motion, the rest raw noise
    function automatic logic [IN_TDATA_W-1:0] random_word();
        int pick, s, px, py, dx, dy, k;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            s  = $urandom_range(0, 1000);
            px = line_x1 + (line_x2 - line_x1) * s / 1000;
            py = line_y1 + (line_y2 - line_y1) * s / 1000;
            dx = int'($urandom_range(0, 600)) - 300;
            dy = int'($urandom_range(0, 600)) - 300;
            k  = $urandom_range(0, 8);
            return move_pair(px + dx, py + dy, px - dx * k / 4, py - dy * k / 4,
                             $urandom_range(0, 60), $urandom_range(0, 60));
        end else if (pick < 85) begin
            px = $urandom_range(0, COORD_MAX);
            py = $urandom_range(0, COORD_MAX);
            return move_pair(px, py,
                             px + int'($urandom_range(0, 300)) - 150,
                             py + int'($urandom_range(0, 300)) - 150,
                             $urandom_range(0, 200), $urandom_range(0, 200));
        end
        return {$urandom, $urandom, $urandom};
    endfunction

    // Offer one word and hold it until taken
    task automatic send_word(input logic [IN_TDATA_W-1:0] w);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = w;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    // Stop offering and wait for every owed result, then let the pipe empty
    task automatic wait_drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        sb.write_reg(idx, val);
    endtask

    // Whole register set; loc and dir carry random upper bits to exercise masking
    task automatic program_line(input int x1, y1, x2, y2, loc, dir);
        line_x1 = x1; line_y1 = y1; line_x2 = x2; line_y2 = y2;
        cfg_write(CFG_SPARE_A, CFG_DATA_W'($urandom));
        cfg_write(CFG_LINE_X1, CFG_DATA_W'(x1));
        cfg_write(CFG_LINE_Y1, CFG_DATA_W'(y1));
        cfg_write(CFG_LINE_X2, CFG_DATA_W'(x2));
        cfg_write(CFG_LINE_Y2, CFG_DATA_W'(y2));
        cfg_write(CFG_TRACK_LOC, CFG_DATA_W'(($urandom & 12'hFF8) | loc));
        cfg_write(CFG_CROSS_DIR, CFG_DATA_W'(($urandom & 12'hFFC) | dir));
        cfg_write(CFG_SPARE_B, CFG_DATA_W'($urandom));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        int ph, n;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        gaps_on       = 1'b1;
        hold_req      = 1'b0;
        line_x1 = 0; line_y1 = 0; line_x2 = 0; line_y2 = 0;
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: degenerate line, nothing can cross
        send_word(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_word(pack_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_word(move_pair(100, 100, 3000, 3000, 5, 5));
        wait_drain();

        // Vertical segment, centre point, any direction
        program_line(2048, 1000, 2048, 3000, LOC_CENTER, DIR_ANY);
        send_word(move_pair(2000, 2000, 2100, 2000, 3, 3));
        send_word(move_pair(2100, 1500, 1990, 2500, 3, 3));
        send_word(move_pair(2048, 2000, 2100, 2000, 3, 3));   // starts on the line
        send_word(move_pair(2000, 2000, 2048, 2000, 3, 3));   // ends on the line
        send_word(move_pair(2000, 3500, 2100, 3500, 3, 3));   // beyond the segment end
        send_word(move_pair(2000, 1000, 2100, 1000, 3, 3));   // through an endpoint
        send_word(move_pair(2048, 500, 2048, 3500, 3, 3));    // along the line
        send_word(move_pair(1000, 2000, 1500, 2100, 3, 3));   // same side
        wait_drain();

        // Diagonal, top point, from the left only; zero edges and inverted boxes
        program_line(0, 0, COORD_MAX, COORD_MAX, LOC_TOP, DIR_FROM_LEFT);
        send_word(move_pair(1000, 2000, 2000, 1000, 4, 4));
        send_word(move_pair(2000, 1000, 1000, 2000, 4, 4));
        send_word(pack_pair(0, 0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_word(pack_pair(COORD_MAX, 0, 0, COORD_MAX, 0, COORD_MAX, COORD_MAX, 0));
        wait_drain();

        // Unused location and unused direction code
        program_line(0, COORD_MAX, COORD_MAX, 0, LOC_SPARE_HI, DIR_SPARE);
        send_word(move_pair(1000, 1000, 3000, 3000, 4, 4));
        send_word(move_pair(3000, 3000, 1000, 1000, 4, 4));
        wait_drain();

        program_line(COORD_MAX, 0, 0, COORD_MAX, LOC_SPARE_LO, DIR_FROM_RIGHT);
        send_word(move_pair(1000, 1000, 3000, 3000, 4, 4));
        send_word(move_pair(3000, 3000, 1000, 1000, 4, 4));
        send_word(move_pair(0, 0, COORD_MAX, COORD_MAX, 0, 0));
        wait_drain();

        // Random phases, each under its own register setting
        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: program_line(0, 0, COORD_MAX, COORD_MAX, LOC_CENTER, DIR_ANY);
                1: program_line(0, COORD_MAX, COORD_MAX, 0, LOC_TOP, DIR_FROM_LEFT);
                2: program_line(0, 0, 0, COORD_MAX, LOC_LEFT, DIR_FROM_RIGHT);
                3: program_line(0, COORD_MAX, COORD_MAX, COORD_MAX, LOC_BOTTOM, DIR_ANY);
                4: program_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, LOC_RIGHT, DIR_ANY);
                default: program_line($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                      $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                      $urandom_range(0, LOC_SPARE_HI),
                                      $urandom_range(0, DIR_SPARE));
            endcase
            gaps_on = (ph != 5);
            for (n = 0; n < PHASE_WORDS; n++) begin
                // long receiver hold while words keep coming
                if (ph == 6 && n == 20) hold_req = 1'b1;
                // sender pauses until all owed results are out
                if (ph == 7 && n == PHASE_WORDS / 2) wait_drain();
                send_word(random_word());
            end
            wait_drain();
        end
        gaps_on = 1'b1;

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** tracked_box_line_crossing: PASSED **");
        end else begin
            $display("** tracked_box_line_crossing: FAILED **");
        end
        $finish;
    end

endmodule
